// ===== sv/csi_escape_sequence_parser_defines.svh =====
// assertion macros for the escape sequence parser
`ifndef CSI_ESCAPE_SEQUENCE_PARSER_DEFINES_SVH
`define CSI_ESCAPE_SEQUENCE_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF

// checked outside reset
`define CSP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define CSP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define CSP_ASSERT(lbl, prop, msg)

`define CSP_ASSERT_RST(lbl, prop, msg)

`endif

`endif

// ===== sv/csp_pkg.sv =====
package csp_pkg;

    // sequence limits
    localparam int MAX_SEQ_LEN = 16;
    localparam int LEN_W       = $clog2(MAX_SEQ_LEN);
    localparam int SLOTS       = 16;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int CNT_W       = SLOT_W + 1;

    // queue between parser and emitter, power of two
    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);

    // special bytes
    localparam logic [7:0] BYTE_ESC  = 8'h1B;
    localparam logic [7:0] BYTE_LBR  = 8'h5B;
    localparam logic [7:0] BYTE_SEMI = 8'h3B;
    localparam logic [7:0] BYTE_ZERO = 8'h30;
    localparam logic [7:0] BYTE_NINE = 8'h39;

    localparam logic [15:0] PARAM_MAX = 16'hFFFF;

    // queue entry kinds
    typedef enum logic [1:0] {
        K_PLAIN = 2'd0,
        K_PARAM = 2'd1,
        K_END   = 2'd2,
        K_ABORT = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [15:0] value;
    } t_entry;

    // write side of the queue
    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_q_wr;

    // read side of the queue
    typedef struct packed {
        logic   empty;
        t_entry entry;
    } t_q_rd;

    typedef struct packed {
        logic                is_plain;
        logic [7:0]          command_byte;
        logic [CNT_W-1:0]    param_count;
        logic [SLOT_W-1:0]   param_index;
        logic [15:0]         param_value;
        logic                last;
    } t_result;

endpackage

// ===== sv/csi_escape_sequence_parser.sv =====
// channel  | direction | handshake        | payload
// ---------+-----------+------------------+--------------------------------------------
// input    | in        | push / full      | i_in_byte
// result   | out       | pop / empty      | o_is_plain, o_command_byte, o_param_count,
//          |           |                  | o_param_index, o_param_value, o_last
//
// input bytes are taken one per cycle while the 4-entry queue behind the parser has room
// a plain character moves from the queue to the output register once it is free; a sequence of
// n parameters leaves the queue as n entries, then each is read from the registered buffer and emitted
// full rises once the queue fills: during long parameter drains or while results sit unpopped
// reset is synchronous, active low, and clears parser, queue and emitter control state
// a result waits in the output register until popped; the parser stalls once the queue fills

module csi_escape_sequence_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    output logic        empty,
    input  logic        pop,
    output logic        o_is_plain,
    output logic [7:0]  o_command_byte,
    output logic [4:0]  o_param_count,
    output logic [3:0]  o_param_index,
    output logic [15:0] o_param_value,
    output logic        o_last
);

    csp_pkg::t_q_wr   q_wr;
    csp_pkg::t_q_rd   q_rd;
    csp_pkg::t_result result;
    logic             q_full;
    logic             q_pop;

    // byte parser
    csp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_byte   (i_in_byte),
        .i_q_full (q_full),
        .o_full   (full),
        .o_q_wr   (q_wr)
    );

    // decoupling queue
    csp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_wr  (q_wr),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_q_rd  (q_rd)
    );

    // result emitter
    csp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_rd   (q_rd),
        .o_q_pop  (q_pop),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_result (result)
    );

    assign o_is_plain     = result.is_plain;
    assign o_command_byte = result.command_byte;
    assign o_param_count  = 5'(result.param_count);
    assign o_param_index  = 4'(result.param_index);
    assign o_param_value  = result.param_value;
    assign o_last         = result.last;

endmodule

// ===== sv/csp_ram.sv =====
module csp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/csp_front.sv =====
module csp_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [7:0]   i_byte,
    input  logic         i_q_full,
    output logic         o_full,
    output csp_pkg::t_q_wr o_q_wr
);

    logic [csp_pkg::LEN_W-1:0]  r_seq_len, n_seq_len;
    logic [csp_pkg::SLOT_W-1:0] r_cur, n_cur;
    logic [15:0]                r_acc, n_acc;

    logic        accept;
    logic        is_digit;
    logic [3:0]  digit;
    logic [19:0] acc_prod;
    logic [15:0] acc_next;
    csp_pkg::t_q_wr q_wr;

    assign o_full = i_q_full;
    assign accept = i_push && !i_q_full;

    // digit classification and saturating acc*10 + d
    assign is_digit = (i_byte >= csp_pkg::BYTE_ZERO) && (i_byte <= csp_pkg::BYTE_NINE);
    assign digit    = 4'(i_byte - csp_pkg::BYTE_ZERO);
    assign acc_prod = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {16'b0, digit};
    assign acc_next = (|acc_prod[19:16]) ? csp_pkg::PARAM_MAX : acc_prod[15:0];

    // byte classification and sequence state
    always_comb begin
        n_seq_len = r_seq_len;
        n_cur     = r_cur;
        n_acc     = r_acc;
        q_wr      = '0;
        if (accept) begin
            if (int'(r_seq_len) >= csp_pkg::MAX_SEQ_LEN - 1) begin
                n_seq_len        = '0;
                n_cur            = '0;
                q_wr.push        = 1'b1;
                q_wr.entry.kind  = csp_pkg::K_ABORT;
            end else if (r_seq_len == '0) begin
                if (i_byte == csp_pkg::BYTE_ESC) begin
                    n_seq_len = csp_pkg::LEN_W'(1);
                    n_cur     = '0;
                    n_acc     = '0;
                end else begin
                    q_wr.push       = 1'b1;
                    q_wr.entry.kind = csp_pkg::K_PLAIN;
                    q_wr.entry.data = i_byte;
                end
            end else if (r_seq_len == csp_pkg::LEN_W'(1)) begin
                if (i_byte == csp_pkg::BYTE_LBR) begin
                    n_seq_len = csp_pkg::LEN_W'(2);
                end else begin
                    n_seq_len = '0;
                end
            end else begin
                n_seq_len = r_seq_len + csp_pkg::LEN_W'(1);
                if (is_digit) begin
                    n_acc = acc_next;
                end else if (i_byte == csp_pkg::BYTE_SEMI) begin
                    if ((int'(r_cur) >= csp_pkg::SLOTS - 1) ||
                        (int'(r_cur) >= csp_pkg::MAX_SEQ_LEN - 1)) begin
                        n_seq_len       = '0;
                        n_cur           = '0;
                        q_wr.push       = 1'b1;
                        q_wr.entry.kind = csp_pkg::K_ABORT;
                    end else begin
                        n_cur            = r_cur + csp_pkg::SLOT_W'(1);
                        n_acc            = '0;
                        q_wr.push        = 1'b1;
                        q_wr.entry.kind  = csp_pkg::K_PARAM;
                        q_wr.entry.value = r_acc;
                    end
                end else begin
                    n_seq_len        = '0;
                    n_cur            = '0;
                    q_wr.push        = 1'b1;
                    q_wr.entry.kind  = csp_pkg::K_END;
                    q_wr.entry.data  = i_byte;
                    q_wr.entry.value = r_acc;
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len <= '0;
            r_cur     <= '0;
        end else begin
            r_seq_len <= n_seq_len;
            r_cur     <= n_cur;
        end
    end

    // parameter accumulator
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_q_wr = q_wr;

endmodule

// ===== sv/csp_queue.sv =====
module csp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  csp_pkg::t_q_wr i_q_wr,
    input  logic           i_pop,
    output logic           o_full,
    output csp_pkg::t_q_rd o_q_rd
);

    csp_pkg::t_entry            r_mem [csp_pkg::FIFO_DEPTH];
    logic [csp_pkg::PTR_W-1:0]  r_wr_ptr;
    logic [csp_pkg::PTR_W-1:0]  r_rd_ptr;
    logic [csp_pkg::PTR_W:0]    r_count;

    logic do_push;
    logic do_pop;
    logic empty;
    logic full;

    assign full    = (r_count == (csp_pkg::PTR_W+1)'(csp_pkg::FIFO_DEPTH));
    assign empty   = (r_count == '0);
    assign do_push = i_q_wr.push && !full;
    assign do_pop  = i_pop && !empty;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + csp_pkg::PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + csp_pkg::PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (csp_pkg::PTR_W+1)'(1);
                2'b01:   r_count <= r_count - (csp_pkg::PTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_q_wr.entry;
        end
    end

    assign o_full       = full;
    assign o_q_rd.empty = empty;
    assign o_q_rd.entry = r_mem[r_rd_ptr];

endmodule

// ===== sv/csp_back.sv =====
`include "csi_escape_sequence_parser_defines.svh"

module csp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  csp_pkg::t_q_rd    i_q_rd,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output csp_pkg::t_result  o_result
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state                      r_state, n_state;
    logic [csp_pkg::SLOT_W-1:0]  r_wcnt, n_wcnt;
    logic [csp_pkg::SLOT_W-1:0]  r_k, n_k;
    logic [csp_pkg::CNT_W-1:0]   r_count, n_count;
    logic [7:0]                  r_cmd, n_cmd;

    logic                        r_out_valid;
    csp_pkg::t_result            r_out;

    logic                        out_free;
    logic                        k_last;
    logic [csp_pkg::CNT_W-1:0]   k_ext;
    logic                        q_pop;
    logic                        load_plain;
    logic                        load_param;
    logic                        ram_we;
    logic                        ram_re;
    logic [15:0]                 ram_rdata;

    assign out_free = !r_out_valid || i_pop;
    assign k_ext    = {1'b0, r_k};
    assign k_last   = (k_ext == r_count - csp_pkg::CNT_W'(1));

    // parameter buffer for the sequence being collected
    csp_ram #(
        .WIDTH (16),
        .DEPTH (csp_pkg::SLOTS)
    ) u_param_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_wcnt),
        .i_wr_data (i_q_rd.entry.value),
        .i_rd_en   (ram_re),
        .i_rd_addr (r_k),
        .o_rd_data (ram_rdata)
    );

    // entry handling and emission sequencer
    always_comb begin
        n_state    = r_state;
        n_wcnt     = r_wcnt;
        n_k        = r_k;
        n_count    = r_count;
        n_cmd      = r_cmd;
        q_pop      = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        load_plain = 1'b0;
        load_param = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_rd.empty) begin
                    case (i_q_rd.entry.kind)
                        csp_pkg::K_PLAIN: begin
                            if (out_free) begin
                                q_pop      = 1'b1;
                                load_plain = 1'b1;
                            end
                        end
                        csp_pkg::K_PARAM: begin
                            q_pop  = 1'b1;
                            ram_we = 1'b1;
                            n_wcnt = r_wcnt + csp_pkg::SLOT_W'(1);
                        end
                        csp_pkg::K_END: begin
                            q_pop   = 1'b1;
                            ram_we  = 1'b1;
                            n_count = {1'b0, r_wcnt} + csp_pkg::CNT_W'(1);
                            n_cmd   = i_q_rd.entry.data;
                            n_k     = '0;
                            n_wcnt  = '0;
                            n_state = ST_READ;
                        end
                        csp_pkg::K_ABORT: begin
                            q_pop  = 1'b1;
                            n_wcnt = '0;
                        end
                        default: begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                ram_re  = 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    load_param = 1'b1;
                    if (k_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k     = r_k + csp_pkg::SLOT_W'(1);
                        n_state = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wcnt  <= n_wcnt;
            if (load_plain || load_param) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // sequence bookkeeping and result register
    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_count <= n_count;
        r_cmd   <= n_cmd;
        if (load_plain) begin
            r_out.is_plain     <= 1'b1;
            r_out.command_byte <= i_q_rd.entry.data;
            r_out.param_count  <= '0;
            r_out.param_index  <= '0;
            r_out.param_value  <= '0;
            r_out.last         <= 1'b1;
        end else if (load_param) begin
            r_out.is_plain     <= 1'b0;
            r_out.command_byte <= r_cmd;
            r_out.param_count  <= r_count;
            r_out.param_index  <= r_k;
            r_out.param_value  <= ram_rdata;
            r_out.last         <= k_last;
        end
    end

    assign o_q_pop  = q_pop;
    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    `CSP_ASSERT_RST(a_reset_idle, !i_rst_n |=> r_state == ST_IDLE && !r_out_valid, "back not idle after reset")
    `CSP_ASSERT(a_read_then_emit, r_state == ST_READ |=> r_state == ST_EMIT, "read not followed by emit")
    `CSP_ASSERT(a_index_in_range, r_state == ST_EMIT |-> k_ext < r_count, "parameter index past count")
    `CSP_ASSERT(a_last_ends_run, r_state == ST_EMIT && out_free && k_last |=> r_state == ST_IDLE && r_out.last, "last parameter did not end run")
    `CSP_ASSERT(a_plain_shape, r_out_valid && r_out.is_plain |-> r_out.last && r_out.param_count == '0, "plain result malformed")

endmodule
